// ===== hw/rtl/bmgf_pkg.sv =====
// package with constants, sequencer states and gf(2^m) multiply steps for berlekamp_massey_gf2m
package bmgf_pkg;

    localparam int FIELD_BITS = 12;
    localparam int T_CORRECT  = 32;
    localparam int COEF_SLOTS = 64;
    localparam int SLOT_W     = $clog2(COEF_SLOTS);
    localparam int STEP_W     = 7;
    localparam int POS_W      = 6;
    localparam int INV_W      = $clog2(FIELD_BITS);
    localparam int LO_BITS    = FIELD_BITS / 2;
    localparam int CFG_W      = 16;
    localparam int ADDR_W     = 3;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * T_CORRECT);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(T_CORRECT);
    localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(COEF_SLOTS - 1);
    localparam logic [INV_W-1:0]  INV_LAST  = INV_W'(FIELD_BITS - 1);

    typedef logic [FIELD_BITS-1:0] gf_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D_RD,
        ST_D_LD,
        ST_D_ACC,
        ST_I_SQ,
        ST_I_SQD,
        ST_I_RES,
        ST_R_LD,
        ST_R_DONE,
        ST_U_RD,
        ST_U_LD,
        ST_U_WR,
        ST_FIN,
        ST_O_RD,
        ST_O_LD,
        ST_O_WAIT,
        ST_MUL1,
        ST_MUL2
    } state_t;

    // one shift-and-reduce step per bit of b
    function automatic gf_t gf_step(gf_t acc, gf_t a, logic bit_b, gf_t poly);
        gf_t r;
        r = {acc[FIELD_BITS-2:0], 1'b0};
        if (acc[FIELD_BITS-1]) r = r ^ poly;
        if (bit_b) r = r ^ a;
        return r;
    endfunction

    // upper bits of b
    function automatic gf_t gf_mul_hi(gf_t a, gf_t b, gf_t poly);
        gf_t acc;
        acc = '0;
        for (int i = FIELD_BITS - 1; i >= LO_BITS; i--) begin
            acc = gf_step(acc, a, b[i], poly);
        end
        return acc;
    endfunction

    // lower bits of b, continuing from the upper part
    function automatic gf_t gf_mul_lo(gf_t acc_in, gf_t a, gf_t b, gf_t poly);
        gf_t acc;
        acc = acc_in;
        for (int i = LO_BITS - 1; i >= 0; i--) begin
            acc = gf_step(acc, a, b[i], poly);
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/berlekamp_massey_gf2m.sv =====
// berlekamp-massey locator solver over gf(2^m) with one shared multiplier worked in hi and lo halves
//
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_syndrome
// m_        out        m_valid/m_ready    m_position, m_coefficient, m_last_of_run
// apb       in         psel/penable       paddr, pwdata, prdata
//
// per syndrome: discrepancy over min(N+1,64) slots, m-1 inversion rounds, ratio, then
// update of all 64 slots, paced by the one shared multiplier and the single read port
// of each coefficient memory; after the last syndrome the T+1 coefficients go out, each
// held until m_ready; reset is synchronous active low; coefficient memories clear
// through valid bits; s_ready is low while a step runs or the locator is being sent

module berlekamp_massey_gf2m
    import bmgf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [11:0]       s_syndrome,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [5:0]        m_position,
    output logic [11:0]       m_coefficient,
    output logic              m_last_of_run,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [CFG_W-1:0]  poly_reg;
    logic [STEP_W-1:0] n_reg, n_next, len_reg, len_next;
    logic [SLOT_W-1:0] j_reg, j_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [INV_W-1:0]  i_reg, i_next;
    gf_t b_reg, b_next, d_reg, d_next, r_reg, r_next;
    gf_t sq_reg, sq_next, res_reg, res_next;
    gf_t ma_reg, ma_next, mb_reg, mb_next, acc_reg, acc_next, prod_reg, prod_next;
    gf_t oldc_reg, oldc_next, oldb_reg, oldb_next, prev_reg, prev_next;
    logic upd_reg, upd_next;
    logic m_valid_reg, m_valid_next;
    logic [POS_W-1:0] m_pos_reg, m_pos_next;
    gf_t m_coef_reg, m_coef_next;
    logic m_last_reg, m_last_next;

    gf_t c_mem [COEF_SLOTS];
    gf_t b_mem [COEF_SLOTS];
    gf_t h_mem [COEF_SLOTS];
    logic [COEF_SLOTS-1:0] c_vld_reg, b_vld_reg;
    gf_t c_q_reg, b_q_reg, h_q_reg;
    logic c_vq_reg, b_vq_reg;
    logic [SLOT_W-1:0] c_aq_reg, b_aq_reg;
    logic [SLOT_W-1:0] c_raddr, h_raddr, d_end;
    gf_t c_val, b_val, poly;
    logic acc_in, cfg_wr, word_done, wr_coef;

    assign poly    = poly_reg[FIELD_BITS-1:0];
    assign acc_in  = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = {16'b0, poly_reg};
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_position    = m_pos_reg;
    assign m_coefficient = m_coef_reg;
    assign m_last_of_run = m_last_reg;

    assign d_end   = n_reg[STEP_W-1] ? SLOT_TOP : n_reg[SLOT_W-1:0];
    assign c_raddr = (state_reg == ST_O_RD) ? (POS_LAST - k_reg) : j_reg;
    assign h_raddr = n_reg[SLOT_W-1:0] - j_reg;
    assign c_val   = c_vq_reg ? c_q_reg : ((c_aq_reg == SLOT_W'(0)) ? gf_t'(1) : '0);
    assign b_val   = b_vq_reg ? b_q_reg : ((b_aq_reg == SLOT_W'(1)) ? gf_t'(1) : '0);
    assign word_done = (state_reg == ST_O_WAIT) && m_ready && m_last_reg;
    assign wr_coef   = (state_reg == ST_U_WR);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_D_RD;
            ST_D_RD:   state_next = ST_D_LD;
            ST_D_LD:   state_next = ST_MUL1;
            ST_D_ACC:  state_next = (j_reg == d_end) ? ST_I_SQ : ST_D_RD;
            ST_I_SQ:   state_next = ST_MUL1;
            ST_I_SQD:  state_next = ST_MUL1;
            ST_I_RES:  state_next = (i_reg == INV_LAST) ? ST_R_LD : ST_I_SQ;
            ST_R_LD:   state_next = ST_MUL1;
            ST_R_DONE: state_next = ST_U_RD;
            ST_U_RD:   state_next = ST_U_LD;
            ST_U_LD:   state_next = ST_MUL1;
            ST_U_WR:   state_next = (j_reg == SLOT_TOP) ? ST_FIN : ST_U_RD;
            ST_FIN:    state_next = (n_reg + STEP_W'(1) == STEP_LAST) ? ST_O_RD : ST_IDLE;
            ST_O_RD:   state_next = ST_O_LD;
            ST_O_LD:   state_next = ST_O_WAIT;
            ST_O_WAIT: begin
                if (m_ready) state_next = m_last_reg ? ST_IDLE : ST_O_RD;
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ret_reg;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ret_next = ret_reg;
        n_next = n_reg; len_next = len_reg; j_next = j_reg; k_next = k_reg; i_next = i_reg;
        b_next = b_reg; d_next = d_reg; r_next = r_reg; sq_next = sq_reg; res_next = res_reg;
        ma_next = ma_reg; mb_next = mb_reg; acc_next = acc_reg; prod_next = prod_reg;
        oldc_next = oldc_reg; oldb_next = oldb_reg; prev_next = prev_reg; upd_next = upd_reg;
        m_valid_next = m_valid_reg; m_pos_next = m_pos_reg;
        m_coef_next = m_coef_reg; m_last_next = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                j_next = '0;
                d_next = '0;
            end
            ST_D_LD: begin
                ma_next = c_val;
                mb_next = h_q_reg;
                ret_next = ST_D_ACC;
            end
            ST_D_ACC: begin
                d_next = d_reg ^ prod_reg;
                j_next = j_reg + SLOT_W'(1);
                sq_next = b_reg;
                res_next = gf_t'(1);
                i_next = INV_W'(1);
            end
            ST_I_SQ: begin
                ma_next = sq_reg;
                mb_next = sq_reg;
                ret_next = ST_I_SQD;
            end
            ST_I_SQD: begin
                sq_next = prod_reg;
                ma_next = res_reg;
                mb_next = prod_reg;
                ret_next = ST_I_RES;
            end
            ST_I_RES: begin
                res_next = prod_reg;
                i_next = i_reg + INV_W'(1);
            end
            ST_R_LD: begin
                ma_next = d_reg;
                mb_next = res_reg;
                ret_next = ST_R_DONE;
            end
            ST_R_DONE: begin
                r_next = prod_reg;
                upd_next = (d_reg != '0) && ({1'b0, len_reg, 1'b0} <= {2'b0, n_reg});
                j_next = '0;
            end
            ST_U_LD: begin
                ma_next = r_reg;
                mb_next = b_val;
                oldc_next = c_val;
                oldb_next = b_val;
                ret_next = ST_U_WR;
            end
            ST_U_WR: begin
                prev_next = upd_reg ? oldc_reg : oldb_reg;
                j_next = j_reg + SLOT_W'(1);
            end
            ST_FIN: begin
                if (upd_reg) begin
                    b_next = d_reg;
                    len_next = n_reg + STEP_W'(1) - len_reg;
                end
                n_next = n_reg + STEP_W'(1);
                k_next = '0;
            end
            ST_O_LD: begin
                m_valid_next = 1'b1;
                m_pos_next = k_reg;
                m_coef_next = c_val;
                m_last_next = (k_reg == POS_LAST);
            end
            ST_O_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    k_next = k_reg + POS_W'(1);
                    if (m_last_reg) begin
                        n_next = '0;
                        len_next = '0;
                        b_next = gf_t'(1);
                    end
                end
            end
            ST_MUL1: acc_next = gf_mul_hi(ma_reg, mb_reg, poly);
            ST_MUL2: prod_next = gf_mul_lo(acc_reg, ma_reg, mb_reg, poly);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            poly_reg    <= CFG_W'(9);
            n_reg       <= '0;
            len_reg     <= '0;
            b_reg       <= gf_t'(1);
            m_valid_reg <= 1'b0;
            c_vld_reg   <= '0;
            b_vld_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            n_reg       <= n_next;
            len_reg     <= len_next;
            b_reg       <= b_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr && (paddr[2] == 1'b0)) poly_reg <= pwdata[CFG_W-1:0];
            if (word_done) begin
                c_vld_reg <= '0;
                b_vld_reg <= '0;
            end else if (wr_coef) begin
                c_vld_reg[j_reg] <= 1'b1;
                b_vld_reg[j_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next; k_reg <= k_next; i_reg <= i_next;
        d_reg <= d_next; r_reg <= r_next; sq_reg <= sq_next; res_reg <= res_next;
        ma_reg <= ma_next; mb_reg <= mb_next; acc_reg <= acc_next; prod_reg <= prod_next;
        oldc_reg <= oldc_next; oldb_reg <= oldb_next; prev_reg <= prev_next;
        upd_reg <= upd_next;
        m_pos_reg <= m_pos_next; m_coef_reg <= m_coef_next; m_last_reg <= m_last_next;
    end

    // coefficient and syndrome memories
    always_ff @(posedge aclk) begin
        c_q_reg  <= c_mem[c_raddr];
        c_vq_reg <= c_vld_reg[c_raddr];
        c_aq_reg <= c_raddr;
        b_q_reg  <= b_mem[j_reg];
        b_vq_reg <= b_vld_reg[j_reg];
        b_aq_reg <= j_reg;
        h_q_reg  <= h_mem[h_raddr];
        if (wr_coef) begin
            c_mem[j_reg] <= oldc_reg ^ prod_reg;
            b_mem[j_reg] <= (j_reg == SLOT_W'(0)) ? gf_t'(0) : prev_reg;
        end
        if (acc_in) h_mem[n_reg[SLOT_W-1:0]] <= s_syndrome[FIELD_BITS-1:0];
    end

    a_ready_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid_reg) else $error("input ready while a result is pending");
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_pos_reg == POS_LAST))
        else $error("last flag away from final position");
    a_disc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        b_reg != '0) else $error("last discrepancy became zero");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= n_reg) else $error("locator length exceeds step count");
    a_out_done: assert property (@(posedge aclk) disable iff (!aresetn)
        word_done |=> (n_reg == '0 && c_vld_reg == '0))
        else $error("state not cleared after the final transfer");

endmodule

// ===== verif/berlekamp_massey_gf2m_tb.sv =====
// testbench for berlekamp_massey_gf2m: locator words checked against a behavioral predictor
`timescale 1ns / 100ps

module berlekamp_massey_gf2m_tb
    import bmgf_pkg::*;
;

    localparam int WORD_LEN   = 2 * T_CORRECT;
    localparam int CYCLE_CAP  = 1500000;
    localparam logic [ADDR_W-1:0] ADDR_FIELD_POLY = ADDR_W'(0);

    typedef struct packed {
        logic [5:0]  position;
        logic [11:0] coefficient;
        logic        last_of_run;
    } coef_out_t;

    logic aclk, aresetn;
    logic s_valid, s_ready;
    logic [11:0] s_syndrome;
    logic m_valid, m_ready;
    logic [5:0] m_position;
    logic [11:0] m_coefficient;
    logic m_last_of_run;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    berlekamp_massey_gf2m uut (.*);

    gf_t poly_shadow;
    gf_t lam[COEF_SLOTS];
    gf_t corr[COEF_SLOTS];
    gf_t synd_ring[COEF_SLOTS];
    gf_t prev_disc;
    logic [6:0] lfsr_len;
    logic [6:0] step_idx;
    coef_out_t locator_q[$];

    int errors;
    int cycles;
    bit idle_on;
    bit hold_armed;
    int hold_left;
    int ready_gap;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic gf_t gf_mult(gf_t a, gf_t b);
        gf_t acc;
        acc = '0;
        for (int i = FIELD_BITS - 1; i >= 0; i--) begin
            if (acc[FIELD_BITS-1]) acc = {acc[FIELD_BITS-2:0], 1'b0} ^ poly_shadow;
            else acc = {acc[FIELD_BITS-2:0], 1'b0};
            if (b[i]) acc = acc ^ a;
        end
        return acc;
    endfunction

    function automatic gf_t gf_recip(gf_t b);
        gf_t sq, res;
        sq = b;
        res = 1;
        for (int i = 1; i < FIELD_BITS; i++) begin
            sq = gf_mult(sq, sq);
            res = gf_mult(res, sq);
        end
        return res;
    endfunction

    task automatic clear_locator();
        for (int j = 0; j < COEF_SLOTS; j++) begin
            lam[j] = '0;
            corr[j] = '0;
        end
        lam[0] = 1;
        corr[1] = 1;
        prev_disc = 1;
        lfsr_len = '0;
        step_idx = '0;
    endtask

    task automatic bm_step(input gf_t syn);
        gf_t disc, ratio, old;
        bit grow;
        coef_out_t c;
        disc = '0;
        synd_ring[step_idx[5:0]] = syn;
        for (int j = 0; j < COEF_SLOTS && j <= step_idx; j++)
            disc = disc ^ gf_mult(lam[j], synd_ring[6'(step_idx - j)]);
        ratio = gf_mult(disc, gf_recip(prev_disc));
        grow = (disc != 0) && ({lfsr_len, 1'b0} <= {1'b0, step_idx});
        for (int j = 0; j < COEF_SLOTS; j++) begin
            old = lam[j];
            lam[j] = old ^ gf_mult(ratio, corr[j]);
            if (grow) corr[j] = old;
        end
        for (int j = COEF_SLOTS - 1; j > 0; j--) corr[j] = corr[j-1];
        corr[0] = '0;
        if (grow) begin
            prev_disc = disc;
            lfsr_len = step_idx + 7'd1 - lfsr_len;
        end
        step_idx = step_idx + 7'd1;
        if (step_idx >= WORD_LEN) begin
            for (int k = 0; k <= T_CORRECT; k++) begin
                c.position = 6'(k);
                c.coefficient = lam[T_CORRECT - k];
                c.last_of_run = (k == T_CORRECT);
                locator_q.push_back(c);
            end
            clear_locator();
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    task automatic send_syndrome(input logic [11:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_syndrome <= v;
        do @(posedge aclk); while (!s_ready);
        bm_step(v);
    endtask

    task automatic write_field_poly(input logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_FIELD_POLY;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        poly_shadow = v[FIELD_BITS-1:0];
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (locator_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_word();
        for (int i = 0; i < WORD_LEN; i++) send_syndrome(12'($urandom));
    endtask

    task automatic test_directed_word();
        logic [11:0] pick[25] = '{12'h000, 12'hfff, 12'h001, 12'h800, 12'h000, 12'h000,
            12'hfff, 12'hfff, 12'h555, 12'haaa, 12'h001, 12'h001, 12'h000, 12'h7ff,
            12'h002, 12'h400, 12'hf0f, 12'h0f0, 12'h000, 12'h800, 12'h123, 12'hedc,
            12'h001, 12'h000, 12'hfff};
        idle_on = 1;
        foreach (pick[i]) send_syndrome(pick[i]);
        for (int i = 25; i < WORD_LEN; i++) send_syndrome(12'($urandom));
        drain();
    endtask

    task automatic test_full_poly_backpressure();
        write_field_poly(16'hffff);
        hold_armed = 1;
        random_word();
        idle_on = 0;
        random_word();
        drain();
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check each transfer, then decide ready for the next cycle
    always @(posedge aclk) begin
        coef_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (locator_q.size() == 0) begin
                report("unexpected transfer", m_position, 0);
            end else begin
                want = locator_q.pop_front();
                if (m_position !== want.position)
                    report("position", m_position, want.position);
                if (m_coefficient !== want.coefficient)
                    report("coefficient", m_coefficient, want.coefficient);
                if (m_last_of_run !== want.last_of_run)
                    report("last_of_run", m_last_of_run, want.last_of_run);
            end
        end
        if (hold_armed && m_valid) begin
            hold_armed <= 0;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            ready_gap <= $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        idle_on = 0;
        hold_armed = 0;
        hold_left = 0;
        ready_gap = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_syndrome = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        poly_shadow = 12'd9;
        for (int j = 0; j < COEF_SLOTS; j++) synd_ring[j] = '0;
        clear_locator();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_word();
        test_full_poly_backpressure();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
